// ----- rtl/quad_motor_mixer_watchdog_core_assert.svh -----
// Assertion helpers for the motor mixer core.
`ifndef QUAD_MOTOR_MIXER_WATCHDOG_CORE_ASSERT_SVH
`define QUAD_MOTOR_MIXER_WATCHDOG_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QMMW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qmmw assertion failed");

// Next-cycle implication, checked out of reset.
`define QMMW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qmmw assertion failed");

`endif

// ----- rtl/qmmw_pkg.sv -----
`default_nettype none

package qmmw_pkg;

   // Fraction bits of the effort values: 1.0 is 1 << FRAC_BITS.
   localparam int FRAC_BITS = 14;

   // Mix sums: clamped thrust plus three 16 bit efforts, with sign.
   localparam int MIX_W    = ((FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17) + 2;
   // Clamped mix (FRAC_BITS+1 bits) times a 16 bit span.
   localparam int PROD_W   = FRAC_BITS + 17;
   localparam int SCALED_W = PROD_W - FRAC_BITS;

   localparam logic [FRAC_BITS:0]        UNIT       = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [MIX_W-1:0]   UNIT_S     = signed'(MIX_W'(UNIT));
   localparam logic [PROD_W-1:0]         ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd2;

   localparam logic [15:0] PULSE_MIN_RESET = 16'd1000;
   localparam logic [15:0] PULSE_MAX_RESET = 16'd2000;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd50;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_ARM   = 2'd1,
      OP_TICK  = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] thrust_in;
      logic signed [15:0] roll_in;
      logic signed [15:0] pitch_in;
      logic signed [15:0] yaw_in;
      logic [31:0]        command_time_ms;
      logic               arm_request;
      logic [31:0]        current_time_ms;
   } req_type;

   typedef struct packed {
      logic [15:0] motor1_us;
      logic [15:0] motor2_us;
      logic [15:0] motor3_us;
      logic [15:0] motor4_us;
      logic        armed_out;
      logic [31:0] command_age_ms;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pulse_min;
      logic [15:0] pulse_max;
   } pulse_cfg_type;

   // Clamp a signed fixed point value to [0, 1].
   function automatic logic [FRAC_BITS:0] clamp_unit(input logic signed [MIX_W-1:0] x);
      logic [FRAC_BITS:0] res;
      if (x < 0) begin
         res = '0;
      end else if (x > UNIT_S) begin
         res = UNIT;
      end else begin
         res = x[FRAC_BITS:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/qmmw_pulse_map.sv -----
`default_nettype none

module qmmw_pulse_map (
   input  wire logic signed [qmmw_pkg::MIX_W-1:0] mix,
   input  wire qmmw_pkg::pulse_cfg_type           cfg,
   output logic [15:0]                            pulse
);
   import qmmw_pkg::*;

   logic [FRAC_BITS:0]  unit_mix;
   logic [15:0]         span;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]   rounded;
   logic [SCALED_W-1:0] scaled;
   logic [SCALED_W:0]   offset;

   // Clamp, scale onto the span with round half up, then offset and clamp.
   always_comb begin
      unit_mix = clamp_unit(mix);
      span     = cfg.pulse_max - cfg.pulse_min;
      prod     = PROD_W'(unit_mix) * PROD_W'(span);
      rounded  = prod + ROUND_HALF;
      scaled   = rounded[PROD_W-1:FRAC_BITS];
      offset   = (SCALED_W+1)'(scaled) + (SCALED_W+1)'(cfg.pulse_min);
      if (cfg.pulse_max < cfg.pulse_min) begin
         pulse = cfg.pulse_max;
      end else if (offset > (SCALED_W+1)'(cfg.pulse_max)) begin
         pulse = cfg.pulse_max;
      end else begin
         pulse = offset[15:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/quad_motor_mixer_watchdog_core.sv -----
// X-frame quadcopter motor mixer with a stale-command watchdog. Each request
// transfer carries an opcode: store a command (thrust, roll, pitch, yaw in
// signed Q2.14 plus a millisecond timestamp), set the armed flag, or tick with
// the current time. Only a tick yields a response transfer, carrying four
// pulse widths (front left, front right, rear left, rear right), the armed
// flag after the tick and the command age. A tick whose command age reaches
// stale_timeout_ms disarms the block and drives all motors at pulse_min_us;
// re-arm with an arm request. Requests are taken one per cycle while no tick
// is held back: each goes into an input register; the mix, the four
// clamp-and-scale lanes (one 15x16 multiply each) and the age compare run
// combinationally on it, and the response lands in an output register. Store
// and arm requests in the input register never wait on the response side; a
// tick waits only while the output register is full and stalled, and the
// requests behind it wait with it. Write CSRs (0 pulse_min_us, 1 pulse_max_us,
// 2 stale_timeout_ms, higher indexes dropped) only while no transfer is in
// flight; csr_ready is always high.
`default_nettype none

`include "quad_motor_mixer_watchdog_core_assert.svh"

module quad_motor_mixer_watchdog_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire qmmw_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output qmmw_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [qmmw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [15:0]                        csr_wdata
);
   import qmmw_pkg::*;

   // Configuration
   pulse_cfg_type cfg_ff, cfg_in;
   logic [15:0]   timeout_ff, timeout_in;

   // Stored command and armed flag
   logic signed [15:0] thrust_ff, thrust_in;
   logic signed [15:0] roll_ff, roll_in;
   logic signed [15:0] pitch_ff, pitch_in;
   logic signed [15:0] yaw_ff, yaw_in;
   logic [31:0]        cmd_time_ff, cmd_time_in;
   logic               armed_ff, armed_in;

   // Input register and output register
   req_type s1_ff, s1_in;
   logic    s1_valid_ff, s1_valid_in;
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;

   logic req_fire, s1_is_tick, s1_advance, out_free;

   // Tick datapath
   logic                      ahead, stale, mix_ok;
   logic [31:0]               age_diff, age;
   logic [FRAC_BITS:0]        thrust_unit;
   logic signed [MIX_W-1:0]   t_s, r_s, p_s, y_s;
   logic signed [MIX_W-1:0]   mix1, mix2, mix3, mix4;
   logic [15:0]               pulse1, pulse2, pulse3, pulse4;
   rsp_type                   tick_rsp;

   // ---------------------------------------------------------------
   // Handshake: store and arm always advance, a tick needs room
   // ---------------------------------------------------------------
   always_comb begin
      s1_is_tick = (s1_ff.opcode == OP_TICK);
      out_free   = !out_valid_ff || !rsp_stall;
      s1_advance = s1_valid_ff && (!s1_is_tick || out_free);
      req_stall  = s1_valid_ff && !s1_advance;
      req_fire   = req_valid && !req_stall;
      rsp_valid  = out_valid_ff;
      rsp_data   = out_ff;
      csr_ready  = 1'b1;
   end

   // ---------------------------------------------------------------
   // Tick: age the command, mix and scale
   // ---------------------------------------------------------------
   always_comb begin
      ahead    = cmd_time_ff > s1_ff.current_time_ms;
      age_diff = s1_ff.current_time_ms - cmd_time_ff;
      age      = ahead ? '0 : age_diff;
      stale    = armed_ff && (age >= 32'(timeout_ff));
      mix_ok   = armed_ff && !stale;

      thrust_unit = clamp_unit(MIX_W'(thrust_ff));
      t_s  = signed'(MIX_W'(thrust_unit));
      r_s  = MIX_W'(roll_ff);
      p_s  = MIX_W'(pitch_ff);
      y_s  = MIX_W'(yaw_ff);
      mix1 = t_s + p_s + r_s - y_s;
      mix2 = t_s + p_s - r_s + y_s;
      mix3 = t_s - p_s + r_s + y_s;
      mix4 = t_s - p_s - r_s - y_s;
   end

   qmmw_pulse_map u_map1 (.mix(mix1), .cfg(cfg_ff), .pulse(pulse1));
   qmmw_pulse_map u_map2 (.mix(mix2), .cfg(cfg_ff), .pulse(pulse2));
   qmmw_pulse_map u_map3 (.mix(mix3), .cfg(cfg_ff), .pulse(pulse3));
   qmmw_pulse_map u_map4 (.mix(mix4), .cfg(cfg_ff), .pulse(pulse4));

   always_comb begin
      // Disarmed or stale: hold every motor at the minimum
      tick_rsp.motor1_us      = mix_ok ? pulse1 : cfg_ff.pulse_min;
      tick_rsp.motor2_us      = mix_ok ? pulse2 : cfg_ff.pulse_min;
      tick_rsp.motor3_us      = mix_ok ? pulse3 : cfg_ff.pulse_min;
      tick_rsp.motor4_us      = mix_ok ? pulse4 : cfg_ff.pulse_min;
      tick_rsp.armed_out      = mix_ok;
      tick_rsp.command_age_ms = armed_ff ? age : '0;
   end

   // ---------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------
   always_comb begin
      cfg_in      = cfg_ff;
      timeout_in  = timeout_ff;
      thrust_in   = thrust_ff;
      roll_in     = roll_ff;
      pitch_in    = pitch_ff;
      yaw_in      = yaw_ff;
      cmd_time_in = cmd_time_ff;
      armed_in    = armed_ff;

      // CSR writes; unknown indexes drop
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PULSE_MIN: cfg_in.pulse_min = csr_wdata;
            CSR_PULSE_MAX: cfg_in.pulse_max = csr_wdata;
            CSR_TIMEOUT:   timeout_in       = csr_wdata;
            default: ;
         endcase
      end

      // Commit the effect of the item leaving the input register
      if (s1_advance) begin
         unique case (s1_ff.opcode)
            OP_STORE: begin
               thrust_in   = s1_ff.thrust_in;
               roll_in     = s1_ff.roll_in;
               pitch_in    = s1_ff.pitch_in;
               yaw_in      = s1_ff.yaw_in;
               cmd_time_in = s1_ff.command_time_ms;
            end
            OP_ARM:  armed_in = s1_ff.arm_request;
            OP_TICK: armed_in = mix_ok;
            default: ;
         endcase
      end

      // Input register: load on transfer, drain on advance
      s1_in = s1_ff;
      if (req_fire) begin
         s1_in       = req_data;
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      // Output register: fill on a tick, drop once taken
      out_in = out_ff;
      if (s1_advance && s1_is_tick) begin
         out_in       = tick_rsp;
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min <= PULSE_MIN_RESET;
         cfg_ff.pulse_max <= PULSE_MAX_RESET;
         timeout_ff       <= TIMEOUT_RESET;
         thrust_ff        <= '0;
         roll_ff          <= '0;
         pitch_ff         <= '0;
         yaw_ff           <= '0;
         cmd_time_ff      <= '0;
         armed_ff         <= 1'b0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         timeout_ff   <= timeout_in;
         thrust_ff    <= thrust_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         cmd_time_ff  <= cmd_time_in;
         armed_ff     <= armed_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      out_ff <= out_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `QMMW_ASSERT_NEXT(a_stale_disarms, clock, reset,
      s1_advance && s1_is_tick && stale, !armed_ff)
   `QMMW_ASSERT_NEXT(a_blocked_item_held, clock, reset,
      s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_ff))
   `QMMW_ASSERT_NOW(a_off_at_min, clock, reset,
      out_valid_ff && !out_ff.armed_out,
      out_ff.motor1_us == cfg_ff.pulse_min && out_ff.motor4_us == cfg_ff.pulse_min)

endmodule

`default_nettype wire

// ----- test/qmmw_motor_checker.sv -----
module qmmw_motor_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire qmmw_pkg::req_type              req_data,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire qmmw_pkg::rsp_type              rsp_data,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [qmmw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                    csr_wdata,
   output int                                  mismatch_total,
   output int                                  frames_in_flight
);
   import qmmw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Shadow registers and stored command.
   logic [15:0]        pw_min;
   logic [15:0]        pw_max;
   logic [15:0]        stale_limit;
   logic signed [15:0] cmd_thrust;
   logic signed [15:0] cmd_roll;
   logic signed [15:0] cmd_pitch;
   logic signed [15:0] cmd_yaw;
   logic [31:0]        cmd_stamp;
   logic               armed;

   rsp_type expected_frames[$];
   int      mismatches = 0;

   function automatic longint to_unit_range(input longint x);
      longint one;
      one = longint'(1) << FRAC_BITS;
      if (x < 0) return 0;
      if (x > one) return one;
      return x;
   endfunction

   // Clamp one mix sum and map it onto the pulse range, rounding half up.
   function automatic logic [15:0] scale_lane(input longint mix);
      longint m;
      longint span;
      longint v;
      m = to_unit_range(mix);
      if (pw_max < pw_min) return pw_max;
      span = longint'(pw_max) - longint'(pw_min);
      v = (m * span + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      v = v + longint'(pw_min);
      if (v > longint'(pw_max)) v = longint'(pw_max);
      return v[15:0];
   endfunction

   // Age the command, update the armed flag and build the pulse frame.
   function automatic rsp_type advance_tick(input logic [31:0] now);
      rsp_type f;
      logic [31:0] age;
      longint t;
      longint r;
      longint p;
      longint y;
      f.motor1_us = pw_min;
      f.motor2_us = pw_min;
      f.motor3_us = pw_min;
      f.motor4_us = pw_min;
      age = '0;
      if (armed) begin
         age = (cmd_stamp <= now) ? now - cmd_stamp : '0;
         if (age >= 32'(stale_limit)) begin
            armed = 1'b0;
         end else begin
            t = to_unit_range(longint'(cmd_thrust));
            r = longint'(cmd_roll);
            p = longint'(cmd_pitch);
            y = longint'(cmd_yaw);
            f.motor1_us = scale_lane(t + p + r - y);
            f.motor2_us = scale_lane(t + p - r + y);
            f.motor3_us = scale_lane(t - p + r + y);
            f.motor4_us = scale_lane(t - p - r - y);
         end
      end
      f.armed_out      = armed;
      f.command_age_ms = age;
      return f;
   endfunction

   task automatic compare_field(input string tag, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         pw_min      = PULSE_MIN_RESET;
         pw_max      = PULSE_MAX_RESET;
         stale_limit = TIMEOUT_RESET;
         cmd_thrust  = '0;
         cmd_roll    = '0;
         cmd_pitch   = '0;
         cmd_yaw     = '0;
         cmd_stamp   = '0;
         armed       = 1'b0;
         expected_frames.delete();
      end else begin
         // A response at this edge belongs to a tick taken at an earlier edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no tick pending, got %h", $time, rsp_data);
            end else begin
               want = expected_frames.pop_front();
               compare_field("motor1_us", 32'(want.motor1_us), 32'(rsp_data.motor1_us));
               compare_field("motor2_us", 32'(want.motor2_us), 32'(rsp_data.motor2_us));
               compare_field("motor3_us", 32'(want.motor3_us), 32'(rsp_data.motor3_us));
               compare_field("motor4_us", 32'(want.motor4_us), 32'(rsp_data.motor4_us));
               compare_field("armed_out", 32'(want.armed_out), 32'(rsp_data.armed_out));
               compare_field("command_age_ms", want.command_age_ms,
                             rsp_data.command_age_ms);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PULSE_MIN: pw_min = csr_wdata;
               CSR_PULSE_MAX: pw_max = csr_wdata;
               CSR_TIMEOUT:   stale_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_data.opcode)
               OP_STORE: begin
                  cmd_thrust = req_data.thrust_in;
                  cmd_roll   = req_data.roll_in;
                  cmd_pitch  = req_data.pitch_in;
                  cmd_yaw    = req_data.yaw_in;
                  cmd_stamp  = req_data.command_time_ms;
               end
               OP_ARM:  armed = req_data.arm_request;
               OP_TICK: expected_frames.push_back(advance_tick(req_data.current_time_ms));
               default: ;
            endcase
         end
      end
      mismatch_total   <= mismatches;
      frames_in_flight <= expected_frames.size();
   end

endmodule

// ----- test/tb_quad_motor_mixer_watchdog_core.sv -----
module tb_quad_motor_mixer_watchdog_core;
   import qmmw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Codes the package leaves unnamed: the spare opcode and the spare CSR slot.
   localparam logic [1:0]           OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 185;
   localparam int HOLD_PHASE     = 6;
   localparam int HOLD_CYCLES    = 300;
   // Margin for a store or arm still in the pipe.
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_wdata = '0;

   int mismatch_total;
   int frames_in_flight;

   // Idle levels 0..3 for each side; 0 means back-to-back transfers.
   int unsigned req_idle = 0;
   int unsigned rsp_idle = 0;
   bit          rsp_hold_go = 1'b0;

   // Timeout shadow used to aim tick times around the stale threshold.
   logic [15:0] cfg_tmo = TIMEOUT_RESET;
   logic [31:0] wall_ms = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quad_motor_mixer_watchdog_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   qmmw_motor_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_total   (mismatch_total),
      .frames_in_flight (frames_in_flight)
   );

   // Fill every field with noise; callers overwrite what their opcode uses,
   // so the don't-care fields still toggle.
   function automatic req_type random_req();
      req_type it;
      it.opcode          = 2'($urandom);
      it.thrust_in       = 16'($urandom);
      it.roll_in         = 16'($urandom);
      it.pitch_in        = 16'($urandom);
      it.yaw_in          = 16'($urandom);
      it.command_time_ms = $urandom;
      it.arm_request     = 1'($urandom);
      it.current_time_ms = $urandom;
      return it;
   endfunction

   function automatic req_type store_cmd(input int thr, input int rol, input int pit,
                                         input int yw, input logic [31:0] stamp);
      req_type it;
      it = random_req();
      it.opcode          = OP_STORE;
      it.thrust_in       = 16'(thr);
      it.roll_in         = 16'(rol);
      it.pitch_in        = 16'(pit);
      it.yaw_in          = 16'(yw);
      it.command_time_ms = stamp;
      return it;
   endfunction

   function automatic req_type arm_cmd(input bit on);
      req_type it;
      it = random_req();
      it.opcode      = OP_ARM;
      it.arm_request = on;
      return it;
   endfunction

   function automatic req_type tick_at(input logic [31:0] now);
      req_type it;
      it = random_req();
      it.opcode          = OP_TICK;
      it.current_time_ms = now;
      return it;
   endfunction

   // Mostly moderate efforts so the mix lands inside [0,1]; sometimes saturate.
   function automatic int pick_effort();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return int'($urandom_range(0, 16000)) - 8000;
      if (sel < 9) return int'($urandom_range(0, 40000)) - 20000;
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // Offer one request transfer; hold valid high and advance once it is taken.
   // An idle burst drops valid first, so valid is never lowered and raised in
   // the same step.
   task automatic offer(input req_type item);
      if (req_idle != 0 && $urandom_range(0, 7) < req_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait for every pending tick to answer, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (frames_in_flight != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back, optionally preceded by a write
   // to the spare index that must be dropped.
   task automatic program_regs(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [15:0] tmo, input bit poke_unused);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [15:0]          val [4];
      int                   k;
      idx[0] = CSR_UNUSED;    val[0] = 16'($urandom);
      idx[1] = CSR_PULSE_MIN; val[1] = lo;
      idx[2] = CSR_PULSE_MAX; val[2] = hi;
      idx[3] = CSR_TIMEOUT;   val[3] = tmo;
      for (k = poke_unused ? 0 : 1; k < 4; k++) begin
         csr_index <= idx[k];
         csr_wdata <= val[k];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_tmo = tmo;
   endtask

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin : rsp_side
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle != 0 && $urandom_range(0, 15) < rsp_idle) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Abort when no transfer happens on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("** quad_motor_mixer_watchdog_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int          phase;
      int          sent;
      int          pick;
      int          burst;
      bit          hold_issued;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] tmo;
      logic [31:0] stamp;
      logic [31:0] now;
      req_type     item;

      hold_issued = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at reset settings: 1000..2000 us, 50 ms timeout.
      offer(tick_at(32'd0));                                 // disarmed tick
      offer(arm_cmd(1'b1));
      offer(tick_at(32'd0));                                 // zero command, age 0
      offer(store_cmd(16384, 0, 0, 0, 32'd100));             // full collective
      offer(tick_at(32'd149));                               // one below timeout
      offer(store_cmd(32767, -32768, 32767, -32768, 32'd200));
      offer(tick_at(32'd200));                               // saturated lanes
      offer(store_cmd(-32768, 32767, -32768, 32767, 32'd300));
      offer(tick_at(32'd301));                               // negative collective
      offer(store_cmd(8192, 1000, -2000, 500, 32'd400));
      offer(tick_at(32'd399));                               // timestamp ahead
      offer(tick_at(32'd450));                               // stale: disarm
      offer(tick_at(32'd451));                               // stays disarmed
      item = '1;                                             // spare opcode, ignored
      offer(item);
      offer(tick_at(32'd452));
      offer(arm_cmd(1'b1));
      offer(store_cmd(4096, 0, 0, 0, 32'hFFFF_FFFF));
      offer(tick_at(32'hFFFF_FFFF));
      offer(tick_at(32'h0000_0010));                         // wrapped: ahead
      offer(store_cmd(8193, 1, 1, 1, 32'd1000));             // rounding edge
      offer(tick_at(32'd1001));
      offer(arm_cmd(1'b0));
      offer(tick_at(32'd1002));
      offer(arm_cmd(1'b1));
      offer(tick_at(32'd1003));
      settle();

      for (phase = 1; phase <= PHASES; phase++) begin
         case (phase)
            1: begin lo = 16'd0;     hi = 16'd65535; tmo = 16'd65535; end
            2: begin lo = 16'd65535; hi = 16'd0;     tmo = 16'd0;     end
            3: begin lo = 16'd1500;  hi = 16'd1200;  tmo = 16'd30;    end
            4: begin lo = PULSE_MIN_RESET; hi = PULSE_MAX_RESET; tmo = TIMEOUT_RESET; end
            5: begin lo = 16'd2000;  hi = 16'd2000;  tmo = 16'd1;     end
            9: begin lo = 16'($urandom); hi = 16'($urandom); tmo = 16'($urandom); end
            default: begin
               lo  = 16'($urandom_range(0, 2000));
               hi  = lo + 16'($urandom_range(0, 3000));
               tmo = 16'($urandom_range(1, 400));
            end
         endcase
         program_regs(lo, hi, tmo, (phase == 4) || ($urandom_range(0, 2) == 0));

         // Start half the phases just below the 32 bit wrap of the clock.
         wall_ms = (phase % 2 == 1) ? 32'hFFFF_FF00 - $urandom_range(0, 2000) : $urandom;
         if (phase == PHASES) begin
            req_idle = 0;
            rsp_idle = 0;
         end else begin
            req_idle = $urandom_range(0, 3);
            rsp_idle = $urandom_range(0, 3);
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (phase != PHASES && $urandom_range(0, 49) == 0) begin
               req_idle = $urandom_range(0, 3);
               rsp_idle = $urandom_range(0, 3);
            end
            // Hold the response side off while ticks keep coming, so the
            // output register fills and the request side backs up.
            if (phase == HOLD_PHASE && !hold_issued && sent >= 40) begin
               hold_issued = 1'b1;
               rsp_hold_go = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               item = random_req();
               offer(item);
               if (item.opcode != OP_UNUSED) sent++;
            end else if (pick < 22) begin
               offer(arm_cmd($urandom_range(0, 9) != 0));
               sent++;
            end else begin
               // Store a command, then tick against it: mostly fresh, some
               // stale, a few with the timestamp ahead of now.
               stamp = wall_ms;
               now   = stamp;
               offer(store_cmd(pick_effort() + 8192, pick_effort(), pick_effort(),
                               pick_effort(), stamp));
               sent++;
               burst = $urandom_range(1, 3);
               repeat (burst) begin
                  pick = $urandom_range(0, 19);
                  if (pick < 2)
                     now = stamp - $urandom_range(1, 100);
                  else if (pick < 5)
                     now = stamp + 32'(cfg_tmo) + $urandom_range(0, 20);
                  else
                     now = stamp + ((cfg_tmo == 0) ? 0 : $urandom_range(0, cfg_tmo - 1));
                  offer(tick_at(now));
                  sent++;
               end
               wall_ms = now + $urandom_range(0, 300);
            end
         end
         settle();
      end

      if (mismatch_total == 0)
         $display("** quad_motor_mixer_watchdog_core: PASSED **");
      else
         $display("** quad_motor_mixer_watchdog_core: FAILED **");
      $finish;
   end

endmodule

// ----- quad_motor_mixer_watchdog_core.f -----
+incdir+rtl
rtl/qmmw_pkg.sv
rtl/qmmw_pulse_map.sv
rtl/quad_motor_mixer_watchdog_core.sv
test/qmmw_motor_checker.sv
test/tb_quad_motor_mixer_watchdog_core.sv
